/* rtl/core/usn_pkg.sv */
// Package for the unit string normalizer: payload types, character codes, state codes.
`timescale 1ns / 1ps
package usn_pkg;

  // Most output bytes that a single input byte can produce.
  localparam int MaxResults = 5;
  localparam int CountW     = $clog2(MaxResults + 1);

  localparam logic [7:0] ChCaret = 8'h5E;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChDot   = 8'h2E;

  // Codes of the first-stage pending register.
  localparam logic [2:0] PendNone    = 3'd0;
  localparam logic [2:0] PendStar    = 3'd1;
  localparam logic [2:0] PendSlash   = 3'd2;
  localparam logic [2:0] PendSpDot   = 3'd3;
  localparam logic [2:0] PendSpSlash = 3'd4;

  typedef struct packed {
    logic [7:0] in_char;
    logic       is_last;
  } usn_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       done_res;
  } usn_out_t;

  typedef struct packed {
    logic [2:0] pend;
    logic       at_start;
    logic       in_run;
    logic       has_slash;
  } usn_state_t;

  localparam usn_state_t StateReset = '{pend: PendNone, at_start: 1'b1,
                                        in_run: 1'b0, has_slash: 1'b0};

endpackage

/* rtl/core/unit_string_normalizer.sv */
// Unit string normalizer top level.
//
// Input channel in_valid_i / in_ready_o / in_data_i carries one byte of a unit
// string per transfer, with is_last set on its final byte. The output channel
// out_valid_o / out_ready_i / out_data_o carries the normalized bytes; the
// final result of each string has done_res set, and a string that normalizes
// to nothing yields one result with char_valid low and done_res high.
// Each accepted byte produces zero to five results, all computed in the cycle
// of the transfer and written into a result buffer; the first of them is
// offered on the next cycle.
// Throughput is one byte per cycle while each byte yields at most one result
// and out_ready_i stays high. A byte that yields n results occupies the buffer
// until all n have transferred, and the next byte is taken in the cycle its last
// result transfers; the single result port is what limits the rate. A byte that
// yields nothing is loaded like any other and leaves the buffer empty.
// When the receiver stalls, results hold; in_ready_o stays low while more than
// one result is held and follows out_ready_i while one is left. Reset empties
// the buffer and returns the normalizer to the start-of-string state.
`timescale 1ns / 1ps
module unit_string_normalizer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  usn_pkg::usn_in_t     in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output usn_pkg::usn_out_t    out_data_o
);
  import usn_pkg::*;

  usn_state_t                state_q, state_d, step_state;
  usn_out_t [MaxResults-1:0] burst;
  logic [CountW-1:0]         count;
  logic                      accept;

  assign accept  = in_valid_i && in_ready_o;
  assign state_d = accept ? step_state : state_q;

  usn_step u_step (
    .item_i  (in_data_i),
    .state_i (state_q),
    .state_o (step_state),
    .burst_o (burst),
    .count_o (count)
  );

  usn_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .burst_i     (burst),
    .count_i     (count),
    .can_load_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/usn_step.sv */
// Next-state and result logic for one input byte of the unit string normalizer.
`timescale 1ns / 1ps
module usn_step (
  input  usn_pkg::usn_in_t                              item_i,
  input  usn_pkg::usn_state_t                           state_i,
  output usn_pkg::usn_state_t                           state_o,
  output usn_pkg::usn_out_t [usn_pkg::MaxResults-1:0]   burst_o,
  output logic [usn_pkg::CountW-1:0]                    count_o
);
  import usn_pkg::*;

  typedef struct packed {
    usn_state_t s;
    logic [1:0] n;
    logic [7:0] b0;
    logic [7:0] b1;
  } push_t;

  // Second stage: drop leading dots and fold dot/slash runs.
  function automatic push_t s2_push(usn_state_t s, logic [7:0] c);
    push_t r;
    r.s  = s;
    r.n  = 2'd0;
    r.b0 = c;
    r.b1 = c;
    if (s.at_start) begin
      if (c != ChDot) begin
        r.s.at_start = 1'b0;
        r.n = 2'd1;
      end
    end else if (s.in_run) begin
      if (c == ChDot || c == ChSlash) begin
        if (c == ChSlash) r.s.has_slash = 1'b1;
      end else begin
        r.b0 = s.has_slash ? ChSlash : ChDot;
        r.n = 2'd2;
        r.s.in_run = 1'b0;
        r.s.has_slash = 1'b0;
      end
    end else if (c == ChDot) begin
      r.s.in_run = 1'b1;
      r.s.has_slash = 1'b0;
    end else begin
      r.n = 2'd1;
    end
    return r;
  endfunction

  logic [7:0]            c;
  logic [2:0]            pend;
  logic                  fresh;
  logic [2:0]            slot_v;
  logic [7:0]            slot_c [3];
  usn_state_t            s;
  push_t                 pr;
  logic [7:0]            chars [MaxResults];
  logic [CountW-1:0]     cnt;

  always_comb begin
    c      = item_i.in_char;
    pend   = state_i.pend;
    fresh  = 1'b0;
    slot_v = '0;
    for (int i = 0; i < 3; i++) slot_c[i] = ChDot;

    // First stage: resolve what was pending from the previous byte.
    unique case (state_i.pend) inside
      PendStar: begin
        pend = PendNone;
        if (c != ChStar) begin
          slot_v[0] = 1'b1;
          fresh = 1'b1;
        end
      end
      PendSlash: begin
        pend = PendNone;
        slot_v[0] = 1'b1;
        if (c != ChSlash) begin
          slot_c[0] = ChSlash;
          fresh = 1'b1;
        end
      end
      PendSpDot, PendSpSlash: begin
        if (c == ChSlash) begin
          pend = PendSpSlash;
        end else if (c != ChSpace) begin
          slot_v[0] = 1'b1;
          slot_c[0] = (state_i.pend == PendSpSlash) ? ChSlash : ChDot;
          pend = PendNone;
          fresh = 1'b1;
        end
      end
      default: begin
        pend = PendNone;
        fresh = 1'b1;
      end
    endcase

    if (fresh) begin
      case (c)
        ChCaret: ;
        ChStar:  pend = PendStar;
        ChSpace: pend = PendSpDot;
        ChSlash: pend = PendSlash;
        default: begin
          slot_v[1] = 1'b1;
          slot_c[1] = c;
        end
      endcase
    end

    // End of string flushes whatever the first stage still holds.
    if (item_i.is_last) begin
      case (pend) inside
        PendStar, PendSpDot: slot_v[2] = 1'b1;
        PendSlash, PendSpSlash: begin
          slot_v[2] = 1'b1;
          slot_c[2] = ChSlash;
        end
        default: ;
      endcase
      pend = PendNone;
    end

    s   = state_i;
    cnt = '0;
    for (int k = 0; k < MaxResults; k++) chars[k] = 8'h00;
    for (int i = 0; i < 3; i++) begin
      pr = s2_push(s, slot_c[i]);
      if (slot_v[i]) begin
        s = pr.s;
        if (pr.n != 2'd0 && cnt < CountW'(MaxResults)) begin
          chars[cnt] = pr.b0;
          cnt = cnt + 1'b1;
        end
        if (pr.n == 2'd2 && cnt < CountW'(MaxResults)) begin
          chars[cnt] = pr.b1;
          cnt = cnt + 1'b1;
        end
      end
    end

    if (item_i.is_last) begin
      // A trailing dot run survives only as a slash.
      if (s.in_run && s.has_slash && cnt < CountW'(MaxResults)) begin
        chars[cnt] = ChSlash;
        cnt = cnt + 1'b1;
      end
      s = StateReset;
    end
    s.pend = pend;
    state_o = s;

    for (int k = 0; k < MaxResults; k++) begin
      burst_o[k].out_char   = chars[k];
      burst_o[k].char_valid = 1'b1;
      burst_o[k].done_res   = item_i.is_last && (CountW'(k + 1) == cnt);
    end
    count_o = cnt;
    if (item_i.is_last && cnt == '0) begin
      burst_o[0] = '{out_char: 8'h00, char_valid: 1'b0, done_res: 1'b1};
      count_o = CountW'(1);
    end
  end

endmodule

/* rtl/core/usn_outbuf.sv */
// Holds one step's bytes and hands out one per cycle while out_ready_i is high.
`timescale 1ns / 1ps
module usn_outbuf (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          load_i,
  input  usn_pkg::usn_out_t [usn_pkg::MaxResults-1:0]   burst_i,
  input  logic [usn_pkg::CountW-1:0]                    count_i,
  output logic                                          can_load_o,
  output logic                                          out_valid_o,
  input  logic                                          out_ready_i,
  output usn_pkg::usn_out_t                             out_data_o
);
  import usn_pkg::*;

  usn_out_t [MaxResults-1:0] buf_q, buf_d;
  logic [CountW-1:0]         rem_q, rem_d;
  logic                      pop;

  assign out_valid_o = (rem_q != '0);
  assign out_data_o  = buf_q[0];
  assign pop         = out_valid_o && out_ready_i;
  // A new burst may enter when empty or when the last held byte leaves in this cycle.
  assign can_load_o  = (rem_q == '0) || (rem_q == CountW'(1) && out_ready_i);

  always_comb begin
    buf_d = buf_q;
    rem_d = rem_q;
    if (load_i) begin
      buf_d = burst_i;
      rem_d = count_i;
    end else if (pop) begin
      buf_d = {buf_q[0], buf_q[MaxResults-1:1]};
      rem_d = rem_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= CountW'(MaxResults))
    else $error("result buffer holds more than a full burst");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> can_load_o)
    else $error("burst loaded over bytes not yet transferred");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !load_i) |=> rem_q == $past(rem_q) - 1'b1)
    else $error("byte count did not drop after a transfer");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.done_res) |-> rem_q == CountW'(1))
    else $error("done marker is not the last byte of its burst");

endmodule
